>>> rtl/ism_pkg.sv
// Shared types and constants for the interval sort and merge block.
// No dependencies; used by the interfaces and every module.
`default_nettype none

package ism_pkg;

   localparam int MAX_RANGES = 32;
   localparam int POS_WIDTH  = 32;

   typedef logic [POS_WIDTH-1:0] pos_type;

   // One slot of the sorted chain.
   typedef struct packed {
      logic    valid;
      pos_type start_pos;
      pos_type end_pos;
   } cell_type;

   // Per-cycle command broadcast to every cell.
   typedef struct packed {
      logic insert;   // place the broadcast range in sorted order
      logic shift;    // move contents one slot toward the head
   } cell_ctl_type;

   // Status from the merge unit back to the sequencer.
   typedef struct packed {
      logic advance;  // head slot consumed this cycle
      logic done;     // final merged range loaded into the response register
   } merge_stat_type;

   typedef enum logic [1:0] {
      PH_COLLECT = 2'b01,
      PH_MERGE   = 2'b10
   } phase_type;

endpackage

`default_nettype wire

>>> rtl/ism_req_if.sv
// Request channel: one range per request, valid/ready handshake.
// Depends on ism_pkg.
`default_nettype none

interface ism_req_if import ism_pkg::*; ();
   logic    valid;
   logic    ready;
   pos_type range_start;
   pos_type range_end;
   logic    last_in;

   modport source (output valid, output range_start, output range_end, output last_in,
                   input ready);
   modport sink   (input valid, input range_start, input range_end, input last_in,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/ism_rsp_if.sv
// Response channel: one merged range per response, valid/ready handshake.
// Depends on ism_pkg.
`default_nettype none

interface ism_rsp_if import ism_pkg::*; ();
   logic    valid;
   logic    ready;
   pos_type merged_start;
   pos_type merged_end;
   logic    last_out;
   logic    dropped;

   modport source (output valid, output merged_start, output merged_end,
                   output last_out, output dropped, input ready);
   modport sink   (input valid, input merged_start, input merged_end,
                   input last_out, input dropped, output ready);
endinterface

`default_nettype wire

>>> rtl/ism_cell.sv
// One slot of the sorted insertion chain.
// Depends on ism_pkg.
`default_nettype none

module ism_cell import ism_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cell_ctl_type ctl,
   input  wire pos_type      item_start,
   input  wire pos_type      item_end,
   input  wire cell_type     left,
   input  wire logic         left_takes,
   input  wire cell_type     right,
   output      cell_type     held,
   output      logic         takes
);

   cell_type slot_ff, slot_in;

   // Empty slots count as +infinity; equal starts stay ahead of the new one.
   assign takes = !slot_ff.valid || (slot_ff.start_pos > item_start);

   always_comb begin
      slot_in = slot_ff;
      if (ctl.shift) begin
         slot_in = right;
      end else if (ctl.insert && takes) begin
         if (left_takes) begin
            slot_in = left;
         end else begin
            slot_in.valid     = 1'b1;
            slot_in.start_pos = item_start;
            slot_in.end_pos   = item_end;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff.start_pos <= slot_in.start_pos;
      slot_ff.end_pos   <= slot_in.end_pos;
      if (reset) begin
         slot_ff.valid <= 1'b0;
      end else begin
         slot_ff.valid <= slot_in.valid;
      end
   end

   assign held = slot_ff;

endmodule

`default_nettype wire

>>> rtl/ism_merge.sv
// Merge unit: folds sorted ranges from the chain head, drives the response register.
// Depends on ism_pkg and ism_rsp_if.
`default_nettype none

module ism_merge import ism_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     active,
   input  wire cell_type head,
   input  wire logic     overflow,
   output merge_stat_type stat,
   ism_rsp_if.source     rsp
);

   logic    have_ff, have_in;
   pos_type run_start_ff, run_start_in;
   pos_type run_end_ff, run_end_in;
   logic    out_valid_ff, out_valid_in;
   pos_type out_start_ff, out_start_in;
   pos_type out_end_ff, out_end_in;
   logic    out_last_ff, out_last_in;
   logic    out_drop_ff, out_drop_in;
   logic    adv;

   assign adv = active && (!out_valid_ff || rsp.ready);

   always_comb begin
      have_in      = have_ff;
      run_start_in = run_start_ff;
      run_end_in   = run_end_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_start_in = out_start_ff;
      out_end_in   = out_end_ff;
      out_last_in  = out_last_ff;
      out_drop_in  = out_drop_ff;
      if (adv) begin
         if (head.valid) begin
            if (!have_ff) begin
               have_in      = 1'b1;
               run_start_in = head.start_pos;
               run_end_in   = head.end_pos;
            end else if (run_end_ff >= head.start_pos) begin
               if (head.end_pos > run_end_ff) begin
                  run_end_in = head.end_pos;
               end
            end else begin
               out_valid_in = 1'b1;
               out_start_in = run_start_ff;
               out_end_in   = run_end_ff;
               out_last_in  = 1'b0;
               out_drop_in  = overflow;
               run_start_in = head.start_pos;
               run_end_in   = head.end_pos;
            end
         end else begin
            // chain drained: flush the open run as the final result
            out_valid_in = 1'b1;
            out_start_in = run_start_ff;
            out_end_in   = run_end_ff;
            out_last_in  = 1'b1;
            out_drop_in  = overflow;
            have_in      = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      run_start_ff <= run_start_in;
      run_end_ff   <= run_end_in;
      out_start_ff <= out_start_in;
      out_end_ff   <= out_end_in;
      out_last_ff  <= out_last_in;
      out_drop_ff  <= out_drop_in;
      if (reset) begin
         have_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         have_ff      <= have_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign stat.advance = adv && head.valid;
   assign stat.done    = adv && !head.valid;

   assign rsp.valid        = out_valid_ff;
   assign rsp.merged_start = out_start_ff;
   assign rsp.merged_end   = out_end_ff;
   assign rsp.last_out     = out_last_ff;
   assign rsp.dropped      = out_drop_ff;

endmodule

`default_nettype wire

>>> rtl/interval_sort_and_merge.sv
// Interval sort and merge: sorted insertion chain plus a streaming merge unit.
// Collect: one range per cycle, inserted into the chain as taken unless it is full.
// Merge: after the request marked last, one chain slot per cycle into the merge
// unit unless the response is stalled, then the final range is flushed.
// No requests are taken during a merge. Synchronous active-high reset empties
// the chain, clears the overflow flag and the response register.
`default_nettype none

module interval_sort_and_merge import ism_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   ism_req_if.sink   req_chan,
   ism_rsp_if.source rsp_chan
);

   phase_type      phase_ff, phase_in;
   logic           overflow_ff, overflow_in;
   cell_type       cells [MAX_RANGES];
   logic           takes [MAX_RANGES];
   cell_ctl_type   ctl;
   merge_stat_type mstat;
   logic           accept;
   logic           full;

   // Chain is full when its tail slot is occupied.
   assign full   = cells[MAX_RANGES-1].valid;
   assign accept = req_chan.valid && req_chan.ready;

   assign req_chan.ready = (phase_ff == PH_COLLECT);

   // Insert while collecting; shift toward the head as the merge unit consumes.
   assign ctl.insert = accept && !full;
   assign ctl.shift  = mstat.advance;

   // Row of slots, each handing contents to its neighbor.
   for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
      cell_type left_cell, right_cell;
      logic     left_tk;
      if (i == 0) begin : g_head
         assign left_cell = '0;
         assign left_tk   = 1'b0;
      end else begin : g_body
         assign left_cell = cells[i-1];
         assign left_tk   = takes[i-1];
      end
      if (i == MAX_RANGES - 1) begin : g_tail
         assign right_cell = '0;
      end else begin : g_inner
         assign right_cell = cells[i+1];
      end
      ism_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .item_start (req_chan.range_start),
         .item_end   (req_chan.range_end),
         .left       (left_cell),
         .left_takes (left_tk),
         .right      (right_cell),
         .held       (cells[i]),
         .takes      (takes[i])
      );
   end

   ism_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .active   (phase_ff == PH_MERGE),
      .head     (cells[0]),
      .overflow (overflow_ff),
      .stat     (mstat),
      .rsp      (rsp_chan)
   );

   // Sequencer: collect until the last range, merge until the final flush.
   always_comb begin
      phase_in    = phase_ff;
      overflow_in = overflow_ff;
      unique case (phase_ff)
         PH_COLLECT: begin
            if (accept && full) begin
               overflow_in = 1'b1;
            end
            if (accept && req_chan.last_in) begin
               phase_in = PH_MERGE;
            end
         end
         PH_MERGE: begin
            if (mstat.done) begin
               phase_in    = PH_COLLECT;
               overflow_in = 1'b0;
            end
         end
         default: begin
            phase_in = PH_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_COLLECT;
         overflow_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         overflow_ff <= overflow_in;
      end
   end

endmodule

`default_nettype wire
